// ----- rtl/hsl_to_rgb_converter_top_assert.svh -----
// Assertion macros for the HSL to RGB converter.
// Included by the modules that check their own pipeline logic; needs clk (and rst).
`ifndef HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Checked on every rising edge of clk, quiet while rst is high.
`define HSLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, for modules without a reset.
`define HSLC_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/hslc_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
// No dependencies.
package hslc_pkg;

  localparam int HUE_W      = 9;
  localparam int CH_W       = 8;
  localparam int HUE_LIMIT  = 360;
  localparam int SECTOR_DEG = 60;
  localparam int FULL       = 255;
  localparam int DENOM      = 30600;

  localparam int KS_W  = 16;
  localparam int T_W   = 6;
  localparam int P_W   = 22;
  localparam int NUM_W = 23;

  localparam int DIV_RECIP = 274;
  localparam int RECIP_W   = 9;
  localparam int DIV_SHIFT = 23;
  localparam int PROD_W    = NUM_W + RECIP_W;
  localparam int Q_W       = PROD_W - DIV_SHIFT;

  localparam int TERM_STAGES = 4;
  localparam int DIV_STAGES  = 2;
  localparam int NUM_STAGES  = TERM_STAGES + DIV_STAGES + 1;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_deg;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  light;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            bad_hue;
  } rgb_t;

  typedef struct packed {
    sector_t sector;
    logic    bad;
  } side_t;

endpackage

// ----- rtl/hsl_to_rgb_converter_top.sv -----
// HSL to RGB converter: takes one colour per clock unless stalled and returns 8-bit red,
// green and blue, truncated, with bad_hue set and all channels zero for a hue of 360 or
// more. Seven register stages: the input register, two chained multipliers, the numerators,
// a two-stage reciprocal divide and the output register. A stalled output holds up a stage
// only when it and every stage ahead of it are full.
// Depends on hslc_pkg, hslc_terms, hslc_div and the assertion macro header.
`include "hsl_to_rgb_converter_top_assert.svh"
module hsl_to_rgb_converter_top
  import hslc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  hsl_t pix,
  output logic rgb_valid,
  input  logic rgb_ready,
  output rgb_t rgb
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  logic [NUM_W-1:0] n_m, n_c, n_x;
  logic [CH_W-1:0]  q_m, q_c, q_x;
  side_t            side4, side5, side6;
  rgb_t             rgb_next;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || rgb_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pix_ready = en[0];
  assign rgb_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pix_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  hslc_terms u_terms (
    .clk  (clk),
    .en   (en[TERM_STAGES-1:0]),
    .pix  (pix),
    .n_m  (n_m),
    .n_c  (n_c),
    .n_x  (n_x),
    .side (side4)
  );

  hslc_div u_div_m (
    .clk     (clk),
    .en      (en[TERM_STAGES+DIV_STAGES-1:TERM_STAGES]),
    .est_vld (vld[TERM_STAGES]),
    .num     (n_m),
    .quo     (q_m)
  );

  hslc_div u_div_c (
    .clk     (clk),
    .en      (en[TERM_STAGES+DIV_STAGES-1:TERM_STAGES]),
    .est_vld (vld[TERM_STAGES]),
    .num     (n_c),
    .quo     (q_c)
  );

  hslc_div u_div_x (
    .clk     (clk),
    .en      (en[TERM_STAGES+DIV_STAGES-1:TERM_STAGES]),
    .est_vld (vld[TERM_STAGES]),
    .num     (n_x),
    .quo     (q_x)
  );

  always_ff @(posedge clk) begin
    if (en[TERM_STAGES]) begin
      side5 <= side4;
    end
    if (en[TERM_STAGES+1]) begin
      side6 <= side5;
    end
  end

  always_comb begin
    rgb_next.bad_hue = side6.bad;
    case (side6.sector)
      SEC_RED_YEL: begin
        rgb_next.red = q_c; rgb_next.green = q_x; rgb_next.blue = q_m;
      end
      SEC_YEL_GRN: begin
        rgb_next.red = q_x; rgb_next.green = q_c; rgb_next.blue = q_m;
      end
      SEC_GRN_CYN: begin
        rgb_next.red = q_m; rgb_next.green = q_c; rgb_next.blue = q_x;
      end
      SEC_CYN_BLU: begin
        rgb_next.red = q_m; rgb_next.green = q_x; rgb_next.blue = q_c;
      end
      SEC_BLU_MAG: begin
        rgb_next.red = q_x; rgb_next.green = q_m; rgb_next.blue = q_c;
      end
      default: begin
        rgb_next.red = q_c; rgb_next.green = q_m; rgb_next.blue = q_x;
      end
    endcase
    if (side6.bad) begin
      rgb_next.red   = '0;
      rgb_next.green = '0;
      rgb_next.blue  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      rgb <= rgb_next;
    end
  end

  `HSLC_ASSERT(a_bad_hue_black,
               (rgb_valid && rgb.bad_hue) |-> (rgb.red == '0 && rgb.green == '0 && rgb.blue == '0),
               "refused hue must give zero channels")
  `HSLC_ASSERT(a_stall_means_full, !pix_ready |-> (&vld), "input stalled with a bubble inside")
  `HSLC_ASSERT(a_advance_to_output, (en[NUM_STAGES-1] && vld[NUM_STAGES-2]) |=> rgb_valid,
               "transaction lost on its way to the output register")

endmodule

// ----- rtl/hslc_terms.sv -----
// Front four pipeline stages: chroma product, hue ramp and the three channel numerators.
// Depends on hslc_pkg.
module hslc_terms
  import hslc_pkg::*;
(
  input  logic                   clk,
  input  logic [TERM_STAGES-1:0] en,
  input  hsl_t                   pix,
  output logic [NUM_W-1:0]       n_m,
  output logic [NUM_W-1:0]       n_c,
  output logic [NUM_W-1:0]       n_x,
  output side_t                  side
);

  logic [HUE_W-1:0] twol;
  logic [HUE_W-1:0] k_full;
  logic [HUE_W-1:0] hm_full;
  logic [6:0]       hm;
  logic [6:0]       t_full;
  sector_t          sector_next;

  logic [CH_W-1:0] k1, sat1, light1;
  logic [T_W-1:0]  t1;
  side_t           side1;

  logic [KS_W-1:0] ks2;
  logic [CH_W-1:0] light2;
  logic [T_W-1:0]  t2;
  side_t           side2;

  logic [KS_W-1:0] ks3;
  logic [P_W-1:0]  p3;
  logic [CH_W-1:0] light3;
  side_t           side3;

  logic [NUM_W-1:0] base;
  logic [NUM_W-1:0] k60;

  always_comb begin
    twol   = {pix.light, 1'b0};
    k_full = (twol >= HUE_W'(FULL)) ? HUE_W'(2 * FULL) - twol : twol;
    if (pix.hue_deg >= HUE_W'(4 * SECTOR_DEG)) begin
      hm_full = pix.hue_deg - HUE_W'(4 * SECTOR_DEG);
    end else if (pix.hue_deg >= HUE_W'(2 * SECTOR_DEG)) begin
      hm_full = pix.hue_deg - HUE_W'(2 * SECTOR_DEG);
    end else begin
      hm_full = pix.hue_deg;
    end
    hm     = hm_full[6:0];
    t_full = (hm >= 7'(SECTOR_DEG)) ? 7'(2 * SECTOR_DEG) - hm : hm;
    if (pix.hue_deg < HUE_W'(SECTOR_DEG)) begin
      sector_next = SEC_RED_YEL;
    end else if (pix.hue_deg < HUE_W'(2 * SECTOR_DEG)) begin
      sector_next = SEC_YEL_GRN;
    end else if (pix.hue_deg < HUE_W'(3 * SECTOR_DEG)) begin
      sector_next = SEC_GRN_CYN;
    end else if (pix.hue_deg < HUE_W'(4 * SECTOR_DEG)) begin
      sector_next = SEC_CYN_BLU;
    end else if (pix.hue_deg < HUE_W'(5 * SECTOR_DEG)) begin
      sector_next = SEC_BLU_MAG;
    end else begin
      sector_next = SEC_MAG_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k1           <= k_full[CH_W-1:0];
      sat1         <= pix.sat;
      light1       <= pix.light;
      t1           <= t_full[T_W-1:0];
      side1.sector <= sector_next;
      side1.bad    <= (pix.hue_deg >= HUE_W'(HUE_LIMIT));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ks2    <= KS_W'(k1) * KS_W'(sat1);
      light2 <= light1;
      t2     <= t1;
      side2  <= side1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ks3    <= ks2;
      p3     <= P_W'(ks2) * P_W'(t2);
      light3 <= light2;
      side3  <= side2;
    end
  end

  always_comb begin
    base = NUM_W'(light3) * NUM_W'(DENOM);
    k60  = NUM_W'(ks3) * NUM_W'(SECTOR_DEG);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      n_m  <= base - k60;
      n_c  <= base + k60;
      n_x  <= base - k60 + NUM_W'({p3, 1'b0});
      side <= side3;
    end
  end

endmodule

// ----- rtl/hslc_div.sv -----
// Two-stage divide by the common denominator: reciprocal multiply, then one correction step.
// Depends on hslc_pkg and the assertion macro header.
`include "hsl_to_rgb_converter_top_assert.svh"
module hslc_div
  import hslc_pkg::*;
(
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic                  est_vld,
  input  logic [NUM_W-1:0]      num,
  output logic [CH_W-1:0]       quo
);

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q0;
  logic [NUM_W-1:0]  num1;
  logic [NUM_W-1:0]  rem;
  logic [Q_W-1:0]    q_fix;

  assign prod = PROD_W'(num) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q0   <= prod[PROD_W-1:DIV_SHIFT];
      num1 <= num;
    end
  end

  always_comb begin
    rem   = num1 - NUM_W'(q0) * NUM_W'(DENOM);
    q_fix = (rem >= NUM_W'(DENOM)) ? q0 + Q_W'(1) : q0;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      quo <= q_fix[CH_W-1:0];
    end
  end

  `HSLC_ASSERT_CLK(a_single_correction, est_vld |-> (rem < NUM_W'(2 * DENOM)),
                   "reciprocal estimate off by more than one")

endmodule

// ----- tb/tb_hsl_to_rgb_converter_top.sv -----
// Self-checking testbench for hsl_to_rgb_converter_top: directed and random colours with a
// local predictor, random stalls on both sides and one long output stall.
// Depends on hslc_pkg and the converter RTL.
`timescale 1ns / 1ps
module tb_hsl_to_rgb_converter_top
  import hslc_pkg::*;
();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_ready;
  hsl_t pix = '0;
  logic rgb_valid;
  logic rgb_ready = 1'b0;
  rgb_t rgb;

  hsl_t hsl_pending[$];
  rgb_t rgb_due[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned stall_seen = 0;
  int unsigned hold_left = 0;

  hsl_to_rgb_converter_top dut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .rgb_valid(rgb_valid),
    .rgb_ready(rgb_ready),
    .rgb(rgb)
  );

  function automatic rgb_t rgb_from_hsl(hsl_t c);
    int unsigned h, s, l, twol, k, ks, hm, t, base, m_v, c_v, x_v;
    sector_t sec;
    rgb_t o;
    h = c.hue_deg;
    s = c.sat;
    l = c.light;
    o = '0;
    if (h >= HUE_LIMIT) begin
      o.bad_hue = 1'b1;
      return o;
    end
    twol = 2 * l;
    k = (twol >= FULL) ? (FULL - (twol - FULL)) : twol;
    ks = k * s;
    hm = h % (2 * SECTOR_DEG);
    t = (hm >= SECTOR_DEG) ? (2 * SECTOR_DEG - hm) : hm;
    base = DENOM * l;
    m_v = (base - SECTOR_DEG * ks) / DENOM;
    c_v = (base + SECTOR_DEG * ks) / DENOM;
    x_v = (base - SECTOR_DEG * ks + 2 * ks * t) / DENOM;
    sec = sector_t'(h / SECTOR_DEG);
    case (sec)
      SEC_RED_YEL: begin o.red = CH_W'(c_v); o.green = CH_W'(x_v); o.blue = CH_W'(m_v); end
      SEC_YEL_GRN: begin o.red = CH_W'(x_v); o.green = CH_W'(c_v); o.blue = CH_W'(m_v); end
      SEC_GRN_CYN: begin o.red = CH_W'(m_v); o.green = CH_W'(c_v); o.blue = CH_W'(x_v); end
      SEC_CYN_BLU: begin o.red = CH_W'(m_v); o.green = CH_W'(x_v); o.blue = CH_W'(c_v); end
      SEC_BLU_MAG: begin o.red = CH_W'(x_v); o.green = CH_W'(m_v); o.blue = CH_W'(c_v); end
      default: begin o.red = CH_W'(c_v); o.green = CH_W'(m_v); o.blue = CH_W'(x_v); end
    endcase
    return o;
  endfunction

  function automatic logic [CH_W-1:0] random_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CH_W'(FULL);
      2: return CH_W'(127 + $urandom_range(0, 1));
      default: return CH_W'($urandom_range(0, FULL));
    endcase
  endfunction

  function automatic hsl_t random_colour();
    hsl_t c;
    case ($urandom_range(0, 9))
      0: c.hue_deg = HUE_W'($urandom_range(HUE_LIMIT, 511));
      1: c.hue_deg = HUE_W'(SECTOR_DEG * $urandom_range(0, 5) + $urandom_range(0, 1));
      default: c.hue_deg = HUE_W'($urandom_range(0, HUE_LIMIT - 1));
    endcase
    c.sat = random_level();
    c.light = random_level();
    return c;
  endfunction

  task automatic queue_colour(int unsigned h, int unsigned s, int unsigned l);
    hsl_t c;
    c.hue_deg = HUE_W'(h);
    c.sat = CH_W'(s);
    c.light = CH_W'(l);
    hsl_pending.push_back(c);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) hsl_pending.push_back(random_colour());
  endtask

  task automatic wait_drained();
    while (hsl_pending.size() != 0 || pix_valid || rgb_due.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // driver: hold the transaction until accepted, then offer the next or idle
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_ready) begin
      if (pix_valid)
        rgb_due.push_back(rgb_from_hsl(pix));
      if (hsl_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pix <= hsl_pending.pop_front();
        pix_valid <= 1'b1;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rgb_ready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      hold_left <= 200;
      rgb_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rgb_ready <= 1'b0;
    end else begin
      rgb_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && rgb_valid && rgb_ready) begin
      if (rgb_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual %h", $time, rgb);
      end else begin
        want = rgb_due.pop_front();
        check_field("red", want.red, rgb.red);
        check_field("green", want.green, rgb.green);
        check_field("blue", want.blue, rgb.blue);
        check_field("bad_hue", want.bad_hue, rgb.bad_hue);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_colour(0, 255, 128);
    queue_colour(59, 255, 128);
    queue_colour(60, 255, 128);
    queue_colour(119, 255, 128);
    queue_colour(120, 255, 128);
    queue_colour(179, 200, 100);
    queue_colour(180, 255, 127);
    queue_colour(239, 255, 128);
    queue_colour(240, 128, 64);
    queue_colour(299, 255, 200);
    queue_colour(300, 255, 128);
    queue_colour(359, 255, 128);
    queue_colour(360, 255, 128);
    queue_colour(511, 255, 255);
    queue_colour(400, 0, 0);
    queue_colour(0, 0, 0);
    queue_colour(0, 0, 255);
    queue_colour(200, 255, 255);
    queue_colour(30, 255, 0);
    queue_colour(90, 0, 128);
    queue_colour(150, 255, 1);
    queue_colour(210, 1, 254);
    queue_colour(270, 255, 127);
    queue_colour(330, 128, 255);
    wait_drained();

    send_idle_pct = 10;
    recv_idle_pct = 85;
    queue_random(450);
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 10;
    queue_random(225);
    wait_drained();
    queue_random(225);
    wait_drained();

    // stall the output while the input keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req++;
    queue_random(60);
    wait_drained();
    queue_random(390);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && rgb_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
